@@ hw/rtl/greedy_lpt_partitioner_macros.svh @@
// Assertion macros for the LPT partitioner.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef GREEDY_LPT_PARTITIONER_MACROS_SVH
`define GREEDY_LPT_PARTITIONER_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define GLP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked on every rising edge outside reset.
`define GLP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ hw/rtl/glp_pkg.sv @@
// Package for the LPT partitioner: sizes, payload structs and the
// controller/datapath command and status structs. No dependencies.
package glp_pkg;
	localparam int MAX_OBJECTS = 64;
	localparam int MAX_PARTS = 16;
	localparam int COST_BITS = 48;
	localparam int ID_W = 6;
	localparam int IDX_W = $clog2(MAX_OBJECTS);
	localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
	localparam int PART_W = 4;
	localparam int PCNT_W = 5;
	localparam int LOAD_W = 54;
	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] NUM_PARTS_RESET = CFG_W'(8);

	typedef struct packed {
		logic [ID_W-1:0] object_id;
		logic [47:0] object_cost;
		logic last_object;
	} obj_req_t;

	typedef struct packed {
		logic [ID_W-1:0] assigned_id;
		logic [PART_W-1:0] part_index;
		logic [LOAD_W-1:0] part_load;
		logic overflowed;
		logic last_result;
	} result_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic part_init;
		logic part_step;
		logic emit;
	} glp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic part_done;
		logic last_emit;
	} glp_sts_t;
endpackage

@@ hw/rtl/glp_ctrl.sv @@
// Controller state machine of the LPT partitioner.
// Depends on glp_pkg; drives glp_datapath through command/status structs.
module glp_ctrl import glp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic last_object,
	input glp_sts_t sts,
	output glp_cmd_t cmd,
	output logic busy
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_PART = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
				if (start && last_object) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					cmd.part_init = 1'b1;
					state_d = ST_PART;
				end
			end
			ST_PART: begin
				cmd.part_step = 1'b1;
				if (sts.part_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d = sts.last_emit ? ST_IDLE : ST_SCAN;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != ST_IDLE);
endmodule

@@ hw/rtl/glp_datapath.sv @@
// Datapath of the LPT partitioner: object store, max search, part loads.
// Depends on glp_pkg; commanded by glp_ctrl.
module glp_datapath import glp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input glp_cmd_t cmd,
	input obj_req_t req,
	input logic [CFG_W-1:0] num_parts,
	output glp_sts_t sts,
	output logic done,
	output result_t result
);
	logic [ID_W+COST_BITS-1:0] mem [MAX_OBJECTS];
	logic [CNT_W-1:0] count_q, rd_idx_q, out_cnt_q;
	logic ovf_q;
	logic [MAX_OBJECTS-1:0] taken_q;
	logic [ID_W+COST_BITS-1:0] rd_data_s1;
	logic [IDX_W-1:0] rd_tag_s1;
	logic rd_vld_s1;
	logic best_vld_q;
	logic [IDX_W-1:0] best_tag_q;
	logic [ID_W-1:0] best_id_q;
	logic [COST_BITS-1:0] best_cost_q;
	logic [LOAD_W-1:0] loads_q [MAX_PARTS];
	logic [PCNT_W-1:0] p_idx_q, parts;
	logic [PART_W-1:0] best_p_q;
	logic [LOAD_W-1:0] best_load_q;
	logic [ID_W-1:0] rd_id;
	logic [COST_BITS-1:0] rd_cost;
	logic better;
	logic [LOAD_W:0] sum;
	logic [LOAD_W-1:0] sat_sum;
	result_t res_q;
	logic done_q;

	always_comb begin
		if (num_parts == '0) parts = PCNT_W'(1);
		else if (num_parts > CFG_W'(MAX_PARTS)) parts = PCNT_W'(MAX_PARTS);
		else parts = num_parts;
	end

	assign rd_id = rd_data_s1[ID_W+COST_BITS-1:COST_BITS];
	assign rd_cost = rd_data_s1[COST_BITS-1:0];
	assign better = !best_vld_q || (rd_cost > best_cost_q) ||
		((rd_cost == best_cost_q) && (rd_id > best_id_q));
	assign sum = {1'b0, best_load_q} + (LOAD_W+1)'(best_cost_q);
	assign sat_sum = sum[LOAD_W] ? {LOAD_W{1'b1}} : sum[LOAD_W-1:0];

	// Store write and registered store read.
	always_ff @(posedge clk) begin
		if (cmd.load && (count_q < CNT_W'(MAX_OBJECTS)))
			mem[count_q[IDX_W-1:0]] <= {req.object_id, req.object_cost[COST_BITS-1:0]};
		rd_data_s1 <= mem[rd_idx_q[IDX_W-1:0]];
		rd_tag_s1 <= rd_idx_q[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && !taken_q[rd_tag_s1] && better) begin
			best_tag_q <= rd_tag_s1;
			best_id_q <= rd_id;
			best_cost_q <= rd_cost;
		end
		if (cmd.part_init) begin
			best_p_q <= '0;
			best_load_q <= loads_q[0];
		end else if (cmd.part_step && (p_idx_q < parts)) begin
			// Ties move to the higher part index.
			if (loads_q[p_idx_q[PART_W-1:0]] <= best_load_q) begin
				best_p_q <= p_idx_q[PART_W-1:0];
				best_load_q <= loads_q[p_idx_q[PART_W-1:0]];
			end
		end
		if (cmd.emit) begin
			res_q.assigned_id <= best_id_q;
			res_q.part_index <= best_p_q;
			res_q.part_load <= sat_sum;
			res_q.overflowed <= ovf_q;
			res_q.last_result <= sts.last_emit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			taken_q <= '0;
			rd_idx_q <= '0;
			rd_vld_s1 <= 1'b0;
			best_vld_q <= 1'b0;
			out_cnt_q <= '0;
			p_idx_q <= '0;
			done_q <= 1'b0;
			for (int i = 0; i < MAX_PARTS; i++) loads_q[i] <= '0;
		end else begin
			done_q <= cmd.emit;
			rd_vld_s1 <= cmd.scan && (rd_idx_q < count_q);
			if (cmd.scan && (rd_idx_q < count_q)) rd_idx_q <= rd_idx_q + CNT_W'(1);
			if (rd_vld_s1 && !taken_q[rd_tag_s1] && better) best_vld_q <= 1'b1;
			if (cmd.load) begin
				if (count_q < CNT_W'(MAX_OBJECTS)) count_q <= count_q + CNT_W'(1);
				else ovf_q <= 1'b1;
				rd_idx_q <= '0;
				best_vld_q <= 1'b0;
			end
			if (cmd.part_init) p_idx_q <= PCNT_W'(1);
			else if (cmd.part_step && (p_idx_q < parts)) p_idx_q <= p_idx_q + PCNT_W'(1);
			if (cmd.emit) begin
				rd_idx_q <= '0;
				best_vld_q <= 1'b0;
				if (sts.last_emit) begin
					// The batch is finished: return to the empty state.
					count_q <= '0;
					ovf_q <= 1'b0;
					taken_q <= '0;
					out_cnt_q <= '0;
					for (int i = 0; i < MAX_PARTS; i++) loads_q[i] <= '0;
				end else begin
					taken_q[best_tag_q] <= 1'b1;
					out_cnt_q <= out_cnt_q + CNT_W'(1);
					loads_q[best_p_q] <= sat_sum;
				end
			end
		end
	end

	assign sts.scan_done = (rd_idx_q == count_q) && !rd_vld_s1;
	assign sts.part_done = (p_idx_q >= parts);
	assign sts.last_emit = ((out_cnt_q + CNT_W'(1)) == count_q);
	assign done = done_q;
	assign result = res_q;
endmodule

@@ hw/rtl/greedy_lpt_partitioner.sv @@
// Greedy LPT partitioner: objects are loaded one per cycle while busy is low;
// the request that carries last_object closes the batch. For each result,
// one pass over the object store through its single registered read port finds
// the largest unassigned object, then one pass over the part loads finds the
// least loaded part. A result is shown for exactly one cycle on done and cannot
// be held off; busy falls with the final result and the next batch may start
// at once.
// Depends on glp_pkg, glp_ctrl, glp_datapath and the assertion macro header.
`include "greedy_lpt_partitioner_macros.svh"
module greedy_lpt_partitioner import glp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input obj_req_t req,
	input logic cfg_we,
	input logic [CFG_W-1:0] cfg_wdata,
	output logic done,
	output result_t result
);
	logic [CFG_W-1:0] num_parts_q;
	glp_cmd_t cmd;
	glp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) num_parts_q <= NUM_PARTS_RESET;
		else if (cfg_we) num_parts_q <= cfg_wdata;
	end

	glp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .last_object(req.last_object),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	glp_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req(req), .num_parts(num_parts_q),
		.sts(sts), .done(done), .result(result)
	);

	`GLP_ASSERT_IMPL(a_done_from_busy, done, $past(busy), "result without a batch in work")
	`GLP_ASSERT_NEXT(a_last_starts, start && !busy && req.last_object, busy, "batch did not start")
	`GLP_ASSERT_IMPL(a_last_frees, done && result.last_result, !busy, "busy after final result")
endmodule
